/* design/redundant_bind_filter_macros.svh */
// Assertion macros for the redundant bind filter.
// Used by the top level; expects signals clk and rst in scope.
`ifndef REDUNDANT_BIND_FILTER_MACROS_SVH
`define REDUNDANT_BIND_FILTER_MACROS_SVH

// Checked only outside reset.
`define RBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define RBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rbf_pkg.sv */
// Shared types and constants for the redundant bind filter.
// No dependencies; imported by every module of the block.
package rbf_pkg;

  localparam int UNITS = 8;
  localparam int UNIT_IDX_W = (UNITS > 1) ? $clog2(UNITS) : 1;

  localparam logic [31:0] UNKNOWN_HANDLE = 32'hffff_ffff;
  localparam logic [5:0]  NO_UNIT        = 6'd63;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    REQ_VAO       = 4'd0,
    REQ_TEX_SAMPLE = 4'd1,
    REQ_TEX       = 4'd2,
    REQ_SELECT    = 4'd3,
    REQ_UBUF      = 4'd4,
    REQ_VAO_DEL   = 4'd5,
    REQ_TEX_DEL   = 4'd6,
    REQ_QUERY     = 4'd7,
    REQ_INVALIDATE = 4'd8,
    REQ_COUNTER   = 4'd9
  } rbf_req_t;

  typedef enum logic [2:0] {
    CMD_SELECT    = 3'd0,
    CMD_BIND_VAO  = 3'd1,
    CMD_BIND_TEX  = 3'd2,
    CMD_BIND_UBUF = 3'd3,
    CMD_ANSWER    = 3'd4
  } rbf_kind_t;

  // One queue entry: the results caused by one request.
  // When two is set, the second result is always a texture bind of val1.
  typedef struct packed {
    logic        two;
    rbf_kind_t   kind0;
    logic [63:0] val0;
    logic [31:0] val1;
  } rbf_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rbf_qstat_t;

endpackage

/* design/redundant_bind_filter.sv */
// Top level of the redundant bind filter: front end, result queue, back end.
// Depends on rbf_pkg, rbf_front, rbf_queue, rbf_back and the macros header.
//
// channel  dir  tdata                          tuser         tlast
// s_       in   handle, unit, counter_sel      req_type      -
// m_       out  cmd_value                      cmd_kind      last
//
// One request transaction is taken per cycle while the 4-entry queue has room.
// Each result is written into the queue before it leaves; a request
// with two results leaves as two output transactions, and the queue absorbs it.
// Requests with no result only update state and leave nothing in the queue.
// rst is synchronous and clears all caches and counters.
// An output stall backs up only through the queue; the front runs until full.
`include "redundant_bind_filter_macros.svh"

module redundant_bind_filter import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // handle[31:0], unit[36:32], counter_sel[38:37], zero pad
  input  logic [3:0]  s_tuser,   // req_type[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // cmd_value[63:0]
  output logic [2:0]  m_tuser,   // cmd_kind[2:0]
  output logic        m_tlast
);

  rbf_entry_t push_entry;
  rbf_entry_t head;
  rbf_qstat_t qstat;
  logic       push;
  logic       pop;

  rbf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .req         (rbf_req_t'(s_tuser)),
    .handle      (s_tdata[31:0]),
    .unit        (s_tdata[36:32]),
    .counter_sel (s_tdata[38:37]),
    .qstat       (qstat),
    .push        (push),
    .entry       (push_entry)
  );

  rbf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (head),
    .qstat    (qstat)
  );

  rbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .kind      (m_tuser),
    .value     (m_tdata),
    .last      (m_tlast)
  );

  // queue bookkeeping: never full and empty at once
  `RBF_ASSERT(a_queue_state, !(qstat.full && qstat.empty), "queue full and empty")
  // answers are always single results
  `RBF_ASSERT(a_answer_last, (m_tvalid && (m_tuser == CMD_ANSWER)) |-> m_tlast, "answer not last")
  // the first of a pair is always a unit select
  `RBF_ASSERT(a_pair_head, (m_tvalid && !m_tlast) |-> (m_tuser == CMD_SELECT), "bad pair head")
  // nothing is offered in the cycle after a reset cycle
  `RBF_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "output valid after reset")

endmodule

/* design/rbf_front.sv */
// Front end: accepts requests, checks them against the binding caches,
// updates state and pushes the resulting commands. Depends on rbf_pkg.
module rbf_front import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rbf_req_t    req,
  input  logic [31:0] handle,
  input  logic [4:0]  unit,
  input  logic [1:0]  counter_sel,
  input  rbf_qstat_t  qstat,
  output logic        push,
  output rbf_entry_t  entry
);

  logic [31:0] cached_vertex_array;
  logic [31:0] cached_uniform_buffer;
  logic [31:0] cached_texture [UNITS];
  logic [5:0]  hit_count [UNITS];
  logic [5:0]  selected_unit;
  logic [63:0] stat_counters [4];

  logic                  acc;
  logic                  cached;
  logic [UNIT_IDX_W-1:0] idx;
  logic                  tex_hit;
  logic                  unit_diff;
  logic                  res;

  assign in_ready  = !qstat.full;
  assign acc       = in_valid && in_ready;
  assign cached    = {1'b0, unit} < 6'(UNITS);
  assign idx       = unit[UNIT_IDX_W-1:0];
  assign tex_hit   = cached && (cached_texture[idx] == handle);
  assign unit_diff = {1'b0, unit} != selected_unit;

  always_comb begin
    res         = 1'b0;
    entry.two   = 1'b0;
    entry.kind0 = CMD_SELECT;
    entry.val0  = 64'({1'b0, unit});
    entry.val1  = handle;
    case (req)
      REQ_VAO: begin
        if (handle != cached_vertex_array) begin
          res         = 1'b1;
          entry.kind0 = CMD_BIND_VAO;
          entry.val0  = 64'(handle);
        end
      end
      REQ_TEX_SAMPLE, REQ_TEX: begin
        if (tex_hit) begin
          res = ((req == REQ_TEX) || (hit_count[idx] == 6'd0)) && unit_diff;
        end else if (unit_diff) begin
          res       = 1'b1;
          entry.two = 1'b1;
        end else begin
          res         = 1'b1;
          entry.kind0 = CMD_BIND_TEX;
          entry.val0  = 64'(handle);
        end
      end
      REQ_SELECT: begin
        res = unit_diff;
      end
      REQ_UBUF: begin
        if (handle != cached_uniform_buffer) begin
          res         = 1'b1;
          entry.kind0 = CMD_BIND_UBUF;
          entry.val0  = 64'(handle);
        end
      end
      REQ_QUERY: begin
        res         = 1'b1;
        entry.kind0 = CMD_ANSWER;
        entry.val0  = 64'(tex_hit);
      end
      REQ_COUNTER: begin
        res         = 1'b1;
        entry.kind0 = CMD_ANSWER;
        entry.val0  = stat_counters[counter_sel];
      end
      default: begin
        res = 1'b0;
      end
    endcase
  end

  assign push = acc && res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cached_vertex_array   <= UNKNOWN_HANDLE;
      cached_uniform_buffer <= UNKNOWN_HANDLE;
      selected_unit         <= NO_UNIT;
      for (int i = 0; i < UNITS; i++) begin
        cached_texture[i] <= UNKNOWN_HANDLE;
        hit_count[i]      <= 6'd0;
      end
      for (int i = 0; i < 4; i++) begin
        stat_counters[i] <= 64'd0;
      end
    end else if (acc) begin
      // any emitted select moves the selected unit
      if (res && (entry.kind0 == CMD_SELECT)) begin
        selected_unit <= {1'b0, unit};
      end
      case (req)
        REQ_VAO: begin
          stat_counters[0] <= stat_counters[0] + 64'd1;
          if (res) begin
            cached_vertex_array <= handle;
            stat_counters[1]    <= stat_counters[1] + 64'd1;
          end
        end
        REQ_TEX_SAMPLE, REQ_TEX: begin
          stat_counters[2] <= stat_counters[2] + 64'd1;
          if (tex_hit) begin
            hit_count[idx] <= hit_count[idx] + 6'd1;
          end else begin
            stat_counters[3] <= stat_counters[3] + 64'd1;
            if (cached) begin
              cached_texture[idx] <= handle;
            end
          end
        end
        REQ_UBUF: begin
          cached_uniform_buffer <= handle;
        end
        REQ_VAO_DEL: begin
          if (cached_vertex_array == handle) begin
            cached_vertex_array <= UNKNOWN_HANDLE;
          end
        end
        REQ_TEX_DEL: begin
          for (int i = 0; i < UNITS; i++) begin
            if (cached_texture[i] == handle) begin
              cached_texture[i] <= UNKNOWN_HANDLE;
            end
          end
        end
        REQ_INVALIDATE: begin
          cached_vertex_array   <= UNKNOWN_HANDLE;
          cached_uniform_buffer <= UNKNOWN_HANDLE;
          selected_unit         <= NO_UNIT;
          for (int i = 0; i < UNITS; i++) begin
            cached_texture[i] <= UNKNOWN_HANDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/rbf_queue.sv */
// Small FIFO of result entries between front and back end.
// Depends on rbf_pkg.
module rbf_queue import rbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rbf_entry_t wr_entry,
  input  logic       pop,
  output rbf_entry_t rd_entry,
  output rbf_qstat_t qstat
);

  rbf_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign qstat.full  = count == (QPTR_W + 1)'(QDEPTH);
  assign qstat.empty = count == '0;
  assign rd_entry    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/rbf_back.sv */
// Back end: plays each queue entry out as one or two output transactions
// and marks the final one. Depends on rbf_pkg.
module rbf_back import rbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rbf_qstat_t  qstat,
  input  rbf_entry_t  head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [63:0] value,
  output logic        last
);

  logic beat;  // 1 while the second result of a pair is on the port

  assign out_valid = !qstat.empty;
  assign last      = !head.two || beat;
  assign kind      = beat ? CMD_BIND_TEX : head.kind0;
  assign value     = beat ? 64'(head.val1) : head.val0;
  assign pop       = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= 1'b0;
    end else if (out_valid && out_ready) begin
      beat <= !last;
    end
  end

endmodule

/* sim/redundant_bind_filter_test.sv */
// Self-checking testbench for redundant_bind_filter: directed corner cases, then random traffic.
// Depends on rbf_pkg and the RTL under design/; the scoreboard class tracks the cache state.

module redundant_bind_filter_test;
  import rbf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REQUEST_TARGET = 1450;
  localparam int FIRST_UNUSED_REQ = int'(REQ_COUNTER) + 1;
  localparam int REQ_CODE_MAX = 2 ** $bits(rbf_req_t) - 1;
  localparam int MAX_UNIT = 31;
  localparam int IDLE_PCT = 26;
  // Receiver blackout: starts after this many requests; the second value sets its length.
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 400;
  // Window of requests with no idling on either side.
  localparam int CALM_FROM = 500;
  localparam int CALM_TO = 800;

  // One downstream command as the filter should emit it.
  typedef struct {
    rbf_kind_t   kind;
    logic [63:0] value;
    logic        last;
  } bind_cmd_t;

  // Shadow of the filter: cached bindings, hit counts, statistics, and the
  // commands still owed by the block in emission order.
  class bind_filter_model;
    logic [31:0] vao_cache;
    logic [31:0] ubuf_cache;
    logic [31:0] tex_cache [UNITS];
    logic [5:0]  cur_unit;
    logic [5:0]  hits [UNITS];
    logic [63:0] stats [4];
    bind_cmd_t   owed_cmds [$];
    int          errors;

    function new();
      clear_bindings();
      foreach (hits[i]) hits[i] = '0;
      foreach (stats[i]) stats[i] = '0;
      errors = 0;
    endfunction

    function void clear_bindings();
      vao_cache = UNKNOWN_HANDLE;
      ubuf_cache = UNKNOWN_HANDLE;
      foreach (tex_cache[i]) tex_cache[i] = UNKNOWN_HANDLE;
      cur_unit = NO_UNIT;
    endfunction

    function void owe(rbf_kind_t kind, logic [63:0] value);
      bind_cmd_t c;
      c.kind = kind;
      c.value = value;
      c.last = 1'b0;
      owed_cmds.push_back(c);
    endfunction

    // A select only goes out when the unit actually changes.
    function void pick_unit(logic [4:0] unit);
      if ({1'b0, unit} != cur_unit) begin
        cur_unit = {1'b0, unit};
        owe(CMD_SELECT, 64'(unit));
      end
    endfunction

    // Called once per accepted request transaction.
    function void accept_request(logic [3:0] req, logic [31:0] handle, logic [4:0] unit,
                                 logic [1:0] sel);
      int        owed_prior;
      int        u;
      bit        in_cache;
      bit        tex_hit;
      bind_cmd_t tail;
      owed_prior = owed_cmds.size();
      u = int'(unit);
      in_cache = u < UNITS;
      tex_hit = in_cache && (tex_cache[in_cache ? u : 0] == handle);
      case (req)
        REQ_VAO: begin
          stats[0]++;
          if (handle != vao_cache) begin
            owe(CMD_BIND_VAO, 64'(handle));
            vao_cache = handle;
            stats[1]++;
          end
        end
        REQ_TEX_SAMPLE, REQ_TEX: begin
          stats[2]++;
          if (tex_hit) begin
            if (req == REQ_TEX) pick_unit(unit);
            // a hit while the hit counter is zero (first hit, or after a wrap) forces a reselect
            if (hits[u] == '0) pick_unit(unit);
            hits[u] = hits[u] + 6'd1;
          end else begin
            pick_unit(unit);
            owe(CMD_BIND_TEX, 64'(handle));
            if (in_cache) tex_cache[u] = handle;
            stats[3]++;
          end
        end
        REQ_SELECT: pick_unit(unit);
        REQ_UBUF: begin
          if (handle != ubuf_cache) begin
            owe(CMD_BIND_UBUF, 64'(handle));
            ubuf_cache = handle;
          end
        end
        REQ_VAO_DEL: if (vao_cache == handle) vao_cache = UNKNOWN_HANDLE;
        REQ_TEX_DEL: foreach (tex_cache[i]) if (tex_cache[i] == handle) tex_cache[i] = UNKNOWN_HANDLE;
        REQ_QUERY: owe(CMD_ANSWER, tex_hit ? 64'd1 : 64'd0);
        REQ_INVALIDATE: clear_bindings();
        REQ_COUNTER: owe(CMD_ANSWER, stats[sel]);
        default: ;  // unused codes are dropped
      endcase
      if (owed_cmds.size() > owed_prior) begin
        tail = owed_cmds.pop_back();
        tail.last = 1'b1;
        owed_cmds.push_back(tail);
      end
    endfunction

    // Called once per accepted command transaction.
    function void check_command(logic [2:0] kind, logic [63:0] value, logic last);
      bind_cmd_t c;
      if (owed_cmds.size() == 0) begin
        $error("unexpected command: cmd_kind %0d cmd_value %h last %b", kind, value, last);
        errors++;
        return;
      end
      c = owed_cmds.pop_front();
      if (kind !== c.kind) begin
        $error("cmd_kind: expected %0d, got %0d", c.kind, kind);
        errors++;
      end
      if (value !== c.value) begin
        $error("cmd_value: expected %h, got %h", c.value, value);
        errors++;
      end
      if (last !== c.last) begin
        $error("last: expected %b, got %b", c.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  bind_filter_model model = new();
  int  requests_sent = 0;
  int  cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  calm;

  assign calm = (requests_sent >= CALM_FROM) && (requests_sent < CALM_TO);

  redundant_bind_filter uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long blackout so the result queue
  // fills and the filter has to drop s_tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && requests_sent >= HOLD_AFTER) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) model.check_command(m_tuser, m_tdata, m_tlast);
  end

  // Offer one request and hold it until the filter takes it. Entered and
  // left right after a rising edge.
  task automatic send_request(logic [3:0] req, logic [31:0] handle, logic [4:0] unit,
                              logic [1:0] sel);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {1'b0, sel, unit, handle};
    do @(posedge clk); while (!s_tready);
    model.accept_request(req, handle, unit, sel);
    if (req <= REQ_COUNTER) requests_sent++;
  endtask

  // Handles: mostly a small pool so bindings repeat and hit, sometimes the
  // unknown marker, sometimes anything.
  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 32'($urandom_range(6, 1));
    if (r < 70) return UNKNOWN_HANDLE;
    return $urandom;
  endfunction

  function automatic logic [4:0] pick_unit_no();
    if ($urandom_range(9) < 8) return 5'($urandom_range(UNITS - 1));
    return 5'($urandom_range(MAX_UNIT));
  endfunction

  task automatic send_random_request();
    int          r;
    logic [3:0]  req;
    r = $urandom_range(99);
    if      (r < 12) req = REQ_VAO;
    else if (r < 32) req = REQ_TEX_SAMPLE;
    else if (r < 52) req = REQ_TEX;
    else if (r < 60) req = REQ_SELECT;
    else if (r < 68) req = REQ_UBUF;
    else if (r < 72) req = REQ_VAO_DEL;
    else if (r < 77) req = REQ_TEX_DEL;
    else if (r < 87) req = REQ_QUERY;
    else if (r < 89) req = REQ_INVALIDATE;
    else if (r < 95) req = REQ_COUNTER;
    else             req = 4'($urandom_range(REQ_CODE_MAX, FIRST_UNUSED_REQ));
    send_request(req, pick_handle(), pick_unit_no(), 2'($urandom_range(3)));
  endtask

  // Bind once, then hammer the same binding so its hit counter can wrap,
  // with selects elsewhere so the forced reselect is visible.
  task automatic send_hit_streak();
    logic [31:0] h;
    logic [4:0]  u;
    int          n;
    h = pick_handle();
    u = 5'($urandom_range(UNITS - 1));
    n = $urandom_range(72, 60);
    send_request(REQ_TEX, h, u, 2'd0);
    repeat (n) begin
      if ($urandom_range(9) < 2) send_request(REQ_SELECT, '0, pick_unit_no(), 2'd0);
      else send_request($urandom_range(3) == 0 ? REQ_TEX : REQ_TEX_SAMPLE, h, u, 2'd0);
    end
  endtask

  // Bind, check, delete, check again, then read a counter.
  task automatic send_bind_query_delete();
    logic [31:0] h;
    logic [4:0]  u;
    h = pick_handle();
    u = pick_unit_no();
    send_request(REQ_TEX, h, u, 2'd0);
    send_request(REQ_QUERY, h, u, 2'd0);
    send_request(REQ_TEX_DEL, h, u, 2'd0);
    send_request(REQ_QUERY, h, u, 2'd0);
    send_request(REQ_COUNTER, '0, '0, 2'($urandom_range(3)));
  endtask

  initial begin
    int r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed corners.
    send_request(REQ_COUNTER, '0, '0, 2'd0);               // counters start at zero
    send_request(REQ_VAO, 32'h0, '0, 2'd0);
    send_request(REQ_VAO, 32'h0, '0, 2'd0);                // redundant, dropped
    send_request(REQ_VAO, UNKNOWN_HANDLE, '0, 2'd0);
    send_request(REQ_VAO_DEL, UNKNOWN_HANDLE, '0, 2'd0);
    send_request(REQ_VAO, UNKNOWN_HANDLE, '0, 2'd0);       // all ones hits unknown cache
    send_request(REQ_TEX_SAMPLE, UNKNOWN_HANDLE, 5'd0, 2'd0); // first hit selects
    send_request(REQ_TEX, 32'h1234_5678, 5'd0, 2'd0);      // miss, unit already current
    send_request(REQ_TEX, 32'h1234_5678, 5'd3, 2'd0);      // miss, select then bind
    send_request(REQ_TEX, 32'h1234_5678, 5'd0, 2'd0);      // non-sampling hit reselects
    send_request(REQ_TEX, 32'h1234_5678, 5'(MAX_UNIT), 2'd0); // beyond UNITS: no cache
    send_request(REQ_QUERY, 32'h1234_5678, 5'(MAX_UNIT), 2'd0);
    send_request(REQ_QUERY, 32'h1234_5678, 5'd3, 2'd0);
    send_request(REQ_TEX_DEL, 32'h1234_5678, '0, 2'd0);    // clears both units
    send_request(REQ_QUERY, 32'h1234_5678, 5'd3, 2'd0);
    send_request(REQ_SELECT, '0, 5'(UNITS - 1), 2'd0);
    send_request(REQ_SELECT, '0, 5'(UNITS - 1), 2'd0);     // no change, dropped
    send_request(REQ_UBUF, 32'ha5a5_5a5a, '0, 2'd0);
    send_request(REQ_UBUF, 32'ha5a5_5a5a, '0, 2'd0);
    send_request(REQ_INVALIDATE, '0, '0, 2'd0);
    send_request(REQ_QUERY, UNKNOWN_HANDLE, 5'd0, 2'd0);
    for (int s = 0; s < 4; s++) send_request(REQ_COUNTER, '0, '0, 2'(s));
    send_request(4'(REQ_CODE_MAX), UNKNOWN_HANDLE, 5'(MAX_UNIT), 2'd3); // ignored
    send_request(4'(FIRST_UNUSED_REQ), '0, '0, 2'd0);                   // ignored

    // Random traffic, mostly well-formed sequences plus loose requests.
    while (requests_sent < REQUEST_TARGET) begin
      r = $urandom_range(99);
      if (r < 3) send_hit_streak();
      else if (r < 15) send_bind_query_delete();
      else send_random_request();
    end
    s_tvalid <= 1'b0;

    // Drain, then give the pipeline time to show any stray command.
    while (model.owed_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (model.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
